// File: src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: src/palr_pkg.sv
package palr_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 4;
  localparam int MAX_KEPT_DEF   = 1024;

  localparam int LEN_BITS     = 32;
  localparam int SAMPLES_BITS = 11;

  localparam logic [LEN_BITS-1:0]     SPACING_RESET      = 32'd1600;
  localparam logic [LEN_BITS-1:0]     MAX_DISTANCE_RESET = 32'd0;
  localparam logic [SAMPLES_BITS-1:0] MAX_SAMPLES_RESET  = 11'd0;

  localparam logic [1:0] REG_SPACING      = 2'd0;
  localparam logic [1:0] REG_MAX_DISTANCE = 2'd1;
  localparam logic [1:0] REG_MAX_SAMPLES  = 2'd2;

  localparam logic KIND_POINT   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [1:0] REASON_HIT      = 2'd0;
  localparam logic [1:0] REASON_DISTANCE = 2'd1;
  localparam logic [1:0] REASON_TIME     = 2'd2;

  function automatic int imax(int a, int b);
    return (a > b) ? a : b;
  endfunction

endpackage

// File: src/palr_point_if.sv
interface palr_point_if #(
  parameter int COORD_BITS = palr_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] point_x;
  logic [COORD_BITS-1:0] point_y;
  logic [COORD_BITS-1:0] point_z;
  logic                  final_point;
  logic                  path_hit;

  modport source (output valid, point_x, point_y, point_z, final_point, path_hit,
                  input ready);
  modport sink (input valid, point_x, point_y, point_z, final_point, path_hit,
                output ready);
endinterface

// File: src/palr_result_if.sv
interface palr_result_if #(
  parameter int COORD_BITS = palr_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  item_kind;
  logic [COORD_BITS-1:0] out_x;
  logic [COORD_BITS-1:0] out_y;
  logic [COORD_BITS-1:0] out_z;
  logic [1:0]            end_reason;
  logic                  run_end;

  modport source (output valid, item_kind, out_x, out_y, out_z, end_reason, run_end,
                  input ready);
  modport sink (input valid, item_kind, out_x, out_y, out_z, end_reason, run_end,
                output ready);
endinterface

// File: src/palr_mul.sv
module palr_mul #(
  parameter int AW = 33,
  parameter int BW = 33,
  parameter int PW = 66
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [AW-1:0] a,
  input  logic [BW-1:0] b,
  input  logic [PW-1:0] acc_in,
  output logic          done,
  output logic [PW-1:0] prod
);
  localparam int CW = $clog2(BW);

  logic [PW-1:0] a_sr;
  logic [BW-1:0] b_sr;
  logic [PW-1:0] acc;
  logic [CW-1:0] cnt;
  logic          busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_sr <= {{(PW-AW){1'b0}}, a};
        b_sr <= b;
        acc  <= acc_in;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (b_sr[0]) begin
          acc <= acc + a_sr;
        end
        a_sr <= {a_sr[PW-2:0], 1'b0};
        b_sr <= {1'b0, b_sr[BW-1:1]};
        cnt  <= cnt + 1'b1;
        if (cnt == CW'(BW-1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign prod = acc;
endmodule

// File: src/palr_sqrt.sv
module palr_sqrt #(
  parameter int RW = 33
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [2*RW-1:0] n,
  output logic            done,
  output logic [RW-1:0]   root
);
  localparam int CW = $clog2(RW);

  logic [2*RW-1:0] n_sr;
  logic [RW+1:0]   rem;
  logic [CW-1:0]   cnt;
  logic            busy;
  logic [RW+1:0]   rem_shift;
  logic [RW+1:0]   trial;

  assign rem_shift = {rem[RW-1:0], n_sr[2*RW-1:2*RW-2]};
  assign trial     = {root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        n_sr <= n;
        rem  <= '0;
        root <= '0;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (rem_shift >= trial) begin
          rem  <= rem_shift - trial;
          root <= {root[RW-2:0], 1'b1};
        end else begin
          rem  <= rem_shift;
          root <= {root[RW-2:0], 1'b0};
        end
        n_sr <= {n_sr[2*RW-3:0], 2'b00};
        cnt  <= cnt + 1'b1;
        if (cnt == CW'(RW-1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// File: src/palr_div.sv
module palr_div #(
  parameter int QW = 33,
  parameter int DW = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [QW+DW-1:0] num,
  input  logic [DW-1:0]    den,
  output logic             done,
  output logic [QW-1:0]    quot
);
  localparam int CW = $clog2(QW);

  logic [DW-1:0] r;
  logic [DW-1:0] d;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   r_shift;
  logic          take;

  assign r_shift = {r, quot[QW-1]};
  assign take    = r_shift >= {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        r    <= num[QW+DW-1:QW];
        quot <= num[QW-1:0];
        d    <= den;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (take) begin
          r <= DW'(r_shift - {1'b0, d});
        end else begin
          r <= r_shift[DW-1:0];
        end
        quot <= {quot[QW-2:0], take};
        cnt  <= cnt + 1'b1;
        if (cnt == CW'(QW-1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// File: src/polyline_arc_length_resampler_unit.sv
// A first point or a point after a cap skips the arithmetic; a point that needs its segment
// length runs the multiplier once per axis and then the square root, and a kept point is
// emitted from S_KEEP_EMIT. A cut at the distance cap adds a multiply and a divide per axis,
// with BW = max(COORD_BITS+1, 32) as the multiplier operand width.
// One point is in work at a time; the bit-serial multiplier and square root set the rate.
// Reset is synchronous and active high; it clears the path state and restores the registers.
module polyline_arc_length_resampler_unit
  import palr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int MAX_KEPT   = MAX_KEPT_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  palr_point_if.sink   points,
  palr_result_if.source results
);
  localparam int C  = COORD_BITS;
  localparam int RW = C + 1;
  localparam int NW = 2 * RW;
  localparam int BW = imax(C + 1, LEN_BITS);
  localparam int PW = C + 1 + BW;
  localparam int ND = C + 1 + LEN_BITS;
  localparam int LW = imax(RW, LEN_BITS);
  localparam int KW = $clog2(MAX_KEPT + 1);
  localparam int CW = imax(KW, SAMPLES_BITS);

  typedef enum logic [3:0] {
    S_IDLE, S_FIRST, S_SQ_GO, S_SQ_WAIT, S_ROOT_GO, S_ROOT_WAIT, S_DECIDE,
    S_IP_GO, S_IP_WAIT, S_DIV_WAIT, S_CUT_EMIT, S_KEEP_EMIT, S_FINAL,
    S_END_EMIT, S_SUM_EMIT
  } state_t;

  state_t state;

  logic [LEN_BITS-1:0]     sample_spacing;
  logic [LEN_BITS-1:0]     max_distance;
  logic [SAMPLES_BITS-1:0] max_samples;

  logic [C-1:0]  cur [3];
  logic          fin;
  logic          hit;
  logic          started;
  logic          stopped;
  logic          distance_capped;
  logic [C-1:0]  previous_point [3];
  logic [C-1:0]  last_kept_point [3];
  logic [C-1:0]  cut_point [3];
  logic [LEN_BITS-1:0] path_length;
  logic [LEN_BITS-1:0] length_since_kept;
  logic [KW-1:0] kept_count;
  logic [1:0]    axis;
  logic [PW-1:0] sq_acc;
  logic [LEN_BITS-1:0] seg;
  logic [LEN_BITS-1:0] rem;

  logic          out_valid;
  logic          out_kind;
  logic [C-1:0]  out_px [3];
  logic [1:0]    out_reason;
  logic          out_end;

  logic          cfg_write;
  logic [C-1:0]  cur_sel;
  logic [C-1:0]  prev_sel;
  logic [C:0]    diff;
  logic          neg;
  logic [C:0]    mag;
  logic          can_load;
  logic          out_load;
  logic [LW-1:0] root_ext;
  logic [LEN_BITS-1:0] seg_next;
  logic [LEN_BITS:0]   path_sum;
  logic [LEN_BITS:0]   lsk_sum;
  logic [LEN_BITS-1:0] path_next;
  logic [LEN_BITS-1:0] lsk_next;
  logic [LEN_BITS-1:0] spacing_eff;
  logic [LEN_BITS-1:0] one_unit;
  logic          cut_hit;
  logic [KW-1:0] kept_bumped;
  logic          count_cap;
  logic          reached_now;
  logic          reached_bumped;
  logic          same_point;
  logic [C-1:0]  interp;

  logic          mul_start;
  logic [BW-1:0] mul_b;
  logic [PW-1:0] mul_acc_in;
  logic          mul_done;
  logic [PW-1:0] mul_prod;
  logic          sqrt_start;
  logic          sqrt_done;
  logic [RW-1:0] sqrt_root;
  logic          div_start;
  logic          div_done;
  logic [RW-1:0] div_quot;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    case (paddr[3:2])
      REG_SPACING:      prdata = sample_spacing;
      REG_MAX_DISTANCE: prdata = max_distance;
      REG_MAX_SAMPLES:  prdata = {{(32-SAMPLES_BITS){1'b0}}, max_samples};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_spacing <= SPACING_RESET;
      max_distance   <= MAX_DISTANCE_RESET;
      max_samples    <= MAX_SAMPLES_RESET;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_SPACING:      sample_spacing <= pwdata;
        REG_MAX_DISTANCE: max_distance   <= pwdata;
        REG_MAX_SAMPLES:  max_samples    <= pwdata[SAMPLES_BITS-1:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    case (axis)
      2'd0:    begin cur_sel = cur[0]; prev_sel = previous_point[0]; end
      2'd1:    begin cur_sel = cur[1]; prev_sel = previous_point[1]; end
      default: begin cur_sel = cur[2]; prev_sel = previous_point[2]; end
    endcase
  end

  assign diff = {cur_sel[C-1], cur_sel} - {prev_sel[C-1], prev_sel};
  assign neg  = diff[C];
  assign mag  = neg ? (~diff + 1'b1) : diff;

  assign root_ext = LW'(sqrt_root);
  assign seg_next = (root_ext > LW'({LEN_BITS{1'b1}})) ? {LEN_BITS{1'b1}}
                                                       : root_ext[LEN_BITS-1:0];

  assign path_sum  = {1'b0, path_length} + {1'b0, seg};
  assign lsk_sum   = {1'b0, length_since_kept} + {1'b0, seg};
  assign path_next = path_sum[LEN_BITS] ? {LEN_BITS{1'b1}} : path_sum[LEN_BITS-1:0];
  assign lsk_next  = lsk_sum[LEN_BITS] ? {LEN_BITS{1'b1}} : lsk_sum[LEN_BITS-1:0];
  assign one_unit  = LEN_BITS'(1) << FRAC_BITS;
  assign spacing_eff = (sample_spacing < one_unit) ? one_unit : sample_spacing;
  assign cut_hit   = (max_distance != '0) && (path_sum > {1'b0, max_distance}) && (seg != '0);

  assign kept_bumped    = (kept_count < KW'(MAX_KEPT)) ? kept_count + 1'b1 : kept_count;
  assign count_cap      = max_samples != '0;
  assign reached_now    = count_cap && (CW'(kept_count) >= CW'(max_samples));
  assign reached_bumped = count_cap && (CW'(kept_bumped) >= CW'(max_samples));
  assign same_point     = (last_kept_point[0] == cur[0]) && (last_kept_point[1] == cur[1])
                          && (last_kept_point[2] == cur[2]);
  assign interp         = neg ? prev_sel - div_quot[C-1:0] : prev_sel + div_quot[C-1:0];

  assign can_load      = !out_valid || results.ready;
  assign out_load      = can_load &&
                         (state inside {S_FIRST, S_CUT_EMIT, S_KEEP_EMIT, S_END_EMIT,
                                        S_SUM_EMIT});
  assign points.ready  = state == S_IDLE;

  assign mul_start  = (state == S_SQ_GO) || (state == S_IP_GO);
  assign mul_b      = (state == S_SQ_GO) ? BW'(mag) : BW'(rem);
  assign mul_acc_in = (state == S_SQ_GO) ? sq_acc : '0;
  assign sqrt_start = state == S_ROOT_GO;
  assign div_start  = (state == S_IP_WAIT) && mul_done;

  palr_mul #(.AW(C + 1), .BW(BW), .PW(PW)) u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mag), .b(mul_b), .acc_in(mul_acc_in),
    .done(mul_done), .prod(mul_prod)
  );

  palr_sqrt #(.RW(RW)) u_sqrt (
    .clk(clk), .rst(rst), .start(sqrt_start), .n(sq_acc[NW-1:0]), .done(sqrt_done),
    .root(sqrt_root)
  );

  palr_div #(.QW(RW), .DW(LEN_BITS)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(mul_prod[ND-1:0]), .den(seg),
    .done(div_done), .quot(div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      started           <= 1'b0;
      stopped           <= 1'b0;
      distance_capped   <= 1'b0;
      path_length       <= '0;
      length_since_kept <= '0;
      kept_count        <= '0;
      axis              <= '0;
      out_valid         <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        previous_point[k]  <= '0;
        last_kept_point[k] <= '0;
      end
    end else begin
      if (out_valid && results.ready && !out_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (points.valid) begin
            cur[0] <= points.point_x;
            cur[1] <= points.point_y;
            cur[2] <= points.point_z;
            fin    <= points.final_point;
            hit    <= points.path_hit;
            axis   <= '0;
            sq_acc <= '0;
            if (!started) begin
              state <= S_FIRST;
            end else if (!stopped) begin
              state <= S_SQ_GO;
            end else begin
              state <= S_FINAL;
            end
          end
        end
        S_FIRST: begin
          if (can_load) begin
            out_valid  <= 1'b1;
            out_kind   <= KIND_POINT;
            out_reason <= REASON_HIT;
            out_end    <= 1'b0;
            for (int k = 0; k < 3; k++) begin
              out_px[k]          <= cur[k];
              previous_point[k]  <= cur[k];
              last_kept_point[k] <= cur[k];
            end
            started           <= 1'b1;
            stopped           <= 1'b0;
            distance_capped   <= 1'b0;
            path_length       <= '0;
            length_since_kept <= '0;
            kept_count        <= KW'(1);
            state             <= S_FINAL;
          end
        end
        S_SQ_GO: begin
          state <= S_SQ_WAIT;
        end
        S_SQ_WAIT: begin
          if (mul_done) begin
            sq_acc <= mul_prod;
            if (axis == 2'd2) begin
              state <= S_ROOT_GO;
            end else begin
              axis  <= axis + 1'b1;
              state <= S_SQ_GO;
            end
          end
        end
        S_ROOT_GO: begin
          state <= S_ROOT_WAIT;
        end
        S_ROOT_WAIT: begin
          if (sqrt_done) begin
            seg   <= seg_next;
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          axis <= '0;
          if (cut_hit) begin
            rem   <= max_distance - path_length;
            state <= S_IP_GO;
          end else begin
            path_length <= path_next;
            for (int k = 0; k < 3; k++) begin
              previous_point[k] <= cur[k];
            end
            if (lsk_next >= spacing_eff) begin
              length_since_kept <= '0;
              state             <= S_KEEP_EMIT;
            end else begin
              length_since_kept <= lsk_next;
              state             <= S_FINAL;
            end
          end
        end
        S_IP_GO: begin
          state <= S_IP_WAIT;
        end
        S_IP_WAIT: begin
          if (mul_done) begin
            state <= S_DIV_WAIT;
          end
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            cut_point[axis] <= interp;
            if (axis == 2'd2) begin
              state <= S_CUT_EMIT;
            end else begin
              axis  <= axis + 1'b1;
              state <= S_IP_GO;
            end
          end
        end
        S_CUT_EMIT: begin
          if (can_load) begin
            out_valid  <= 1'b1;
            out_kind   <= KIND_POINT;
            out_reason <= REASON_HIT;
            out_end    <= 1'b0;
            for (int k = 0; k < 3; k++) begin
              out_px[k]          <= cut_point[k];
              last_kept_point[k] <= cut_point[k];
            end
            kept_count      <= kept_bumped;
            path_length     <= max_distance;
            distance_capped <= 1'b1;
            stopped         <= 1'b1;
            state           <= S_FINAL;
          end
        end
        S_KEEP_EMIT: begin
          if (can_load) begin
            out_valid  <= 1'b1;
            out_kind   <= KIND_POINT;
            out_reason <= REASON_HIT;
            out_end    <= 1'b0;
            for (int k = 0; k < 3; k++) begin
              out_px[k]          <= cur[k];
              last_kept_point[k] <= cur[k];
            end
            kept_count <= kept_bumped;
            if (reached_bumped) begin
              stopped <= 1'b1;
            end
            state <= S_FINAL;
          end
        end
        S_FINAL: begin
          if (!fin) begin
            state <= S_IDLE;
          end else if (!distance_capped && !reached_now && !same_point) begin
            state <= S_END_EMIT;
          end else begin
            state <= S_SUM_EMIT;
          end
        end
        S_END_EMIT: begin
          if (can_load) begin
            out_valid  <= 1'b1;
            out_kind   <= KIND_POINT;
            out_reason <= REASON_HIT;
            out_end    <= 1'b0;
            for (int k = 0; k < 3; k++) begin
              out_px[k]          <= cur[k];
              last_kept_point[k] <= cur[k];
            end
            kept_count <= kept_bumped;
            state      <= S_SUM_EMIT;
          end
        end
        S_SUM_EMIT: begin
          if (can_load) begin
            out_valid <= 1'b1;
            out_kind  <= KIND_SUMMARY;
            out_end   <= 1'b1;
            for (int k = 0; k < 3; k++) begin
              out_px[k] <= '0;
            end
            if (distance_capped) begin
              out_reason <= REASON_DISTANCE;
            end else if (hit) begin
              out_reason <= REASON_HIT;
            end else begin
              out_reason <= REASON_TIME;
            end
            started         <= 1'b0;
            stopped         <= 1'b0;
            distance_capped <= 1'b0;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign results.valid      = out_valid;
  assign results.item_kind  = out_kind;
  assign results.out_x      = out_px[0];
  assign results.out_y      = out_px[1];
  assign results.out_z      = out_px[2];
  assign results.end_reason = out_reason;
  assign results.run_end    = out_end;
endmodule

// File: src/palr_checker.sv
`include "assert_macros.svh"

module palr_checker
  import palr_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_kind,
  input logic [1:0] out_reason,
  input logic       out_end
);
  logic summary_ok;

  assign summary_ok = out_end && (out_reason == REASON_HIT || out_reason == REASON_DISTANCE ||
                                  out_reason == REASON_TIME);

  `ASSERT_NEXT(a_out_holds, clk, rst, out_valid && !out_ready, out_valid)
  `ASSERT_SAME(a_summary_fields, clk, rst, out_valid && out_kind == KIND_SUMMARY, summary_ok)
  `ASSERT_SAME(a_point_fields, clk, rst, out_valid && out_kind == KIND_POINT, !out_end && out_reason == REASON_HIT)
  `ASSERT_NEXT(a_one_in_work, clk, rst, in_valid && in_ready, !in_ready)
endmodule

bind polyline_arc_length_resampler_unit palr_checker u_palr_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(points.valid),
  .in_ready(points.ready),
  .out_valid(results.valid),
  .out_ready(results.ready),
  .out_kind(results.item_kind),
  .out_reason(results.end_reason),
  .out_end(results.run_end)
);

// File: verif/palr_path_checker.sv
module palr_path_checker
  import palr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  palr_point_if       pts,
  palr_result_if      res,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] LEN_SAT = 64'hFFFF_FFFF;

  typedef struct {
    logic        kind;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [1:0]  reason;
    logic        run_end;
  } beat_t;

  beat_t expected_beats[$];
  int    err_count = 0;

  logic [31:0] spacing_reg;
  logic [31:0] max_dist_reg;
  logic [10:0] max_kept_reg;

  logic        started;
  logic        stopped;
  logic        dist_capped;
  longint      prev_pt[3];
  longint      kept_pt[3];
  logic [63:0] path_len;
  logic [63:0] since_kept;
  int          kept_count;

  assign errors  = err_count;
  assign pending = expected_beats.size();

  function automatic logic [63:0] isqrt(logic [127:0] n);
    logic [63:0]  r;
    logic [127:0] c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = {64'd0, r | (64'd1 << b)};
      if (c * c <= n) r = c[63:0];
    end
    return r;
  endfunction

  function automatic logic [63:0] abs64(longint d);
    return (d < 0) ? 64'(-d) : 64'(d);
  endfunction

  function automatic logic [63:0] segment_length(longint cur[3]);
    logic [127:0] acc;
    logic [63:0]  ad;
    logic [63:0]  r;
    acc = '0;
    for (int k = 0; k < 3; k++) begin
      ad  = abs64(cur[k] - prev_pt[k]);
      acc = acc + {64'd0, ad} * {64'd0, ad};
    end
    r = isqrt(acc);
    return (r > LEN_SAT) ? LEN_SAT : r;
  endfunction

  function automatic logic [63:0] sat_len(logic [63:0] a, logic [63:0] b);
    return (a + b > LEN_SAT) ? LEN_SAT : a + b;
  endfunction

  task automatic push_point(longint p[3]);
    beat_t b;
    b.kind    = KIND_POINT;
    b.x       = p[0][31:0];
    b.y       = p[1][31:0];
    b.z       = p[2][31:0];
    b.reason  = REASON_HIT;
    b.run_end = 1'b0;
    expected_beats.push_back(b);
    for (int k = 0; k < 3; k++) kept_pt[k] = p[k];
    if (kept_count < MAX_KEPT_DEF) kept_count++;
  endtask

  task automatic advance_path(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              logic fin, logic hit);
    longint       p[3];
    longint       e[3];
    longint       d;
    logic [63:0]  seg;
    logic [63:0]  rem;
    logic [63:0]  spacing;
    logic [127:0] q;
    logic         count_cap;
    logic         same;
    beat_t        s;
    p[0] = longint'($signed(x));
    p[1] = longint'($signed(y));
    p[2] = longint'($signed(z));
    spacing   = (spacing_reg < (32'd1 << FRAC_BITS_DEF)) ? (64'd1 << FRAC_BITS_DEF)
                                                          : {32'd0, spacing_reg};
    count_cap = (max_kept_reg != 0);
    if (!started) begin
      started     = 1'b1;
      stopped     = 1'b0;
      dist_capped = 1'b0;
      for (int k = 0; k < 3; k++) prev_pt[k] = p[k];
      path_len   = '0;
      since_kept = '0;
      kept_count = 0;
      push_point(p);
    end else if (!stopped) begin
      seg = segment_length(p);
      if (max_dist_reg != 0 && path_len + seg > {32'd0, max_dist_reg} && seg != 0) begin
        rem = {32'd0, max_dist_reg} - path_len;
        for (int k = 0; k < 3; k++) begin
          d = p[k] - prev_pt[k];
          q = ({64'd0, abs64(d)} * {64'd0, rem}) / {64'd0, seg};
          e[k] = (d < 0) ? prev_pt[k] - longint'(q[63:0]) : prev_pt[k] + longint'(q[63:0]);
        end
        push_point(e);
        path_len    = {32'd0, max_dist_reg};
        dist_capped = 1'b1;
        stopped     = 1'b1;
      end else begin
        path_len   = sat_len(path_len, seg);
        since_kept = sat_len(since_kept, seg);
        if (since_kept >= spacing) begin
          push_point(p);
          since_kept = '0;
          if (count_cap && kept_count >= max_kept_reg) stopped = 1'b1;
        end
        for (int k = 0; k < 3; k++) prev_pt[k] = p[k];
      end
    end
    if (fin) begin
      if (!dist_capped) begin
        same = (kept_pt[0] == p[0]) && (kept_pt[1] == p[1]) && (kept_pt[2] == p[2]);
        if (!(count_cap && kept_count >= max_kept_reg) && !same) push_point(p);
      end
      s.kind    = KIND_SUMMARY;
      s.x       = '0;
      s.y       = '0;
      s.z       = '0;
      s.reason  = dist_capped ? REASON_DISTANCE : (hit ? REASON_HIT : REASON_TIME);
      s.run_end = 1'b1;
      expected_beats.push_back(s);
      started     = 1'b0;
      stopped     = 1'b0;
      dist_capped = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    beat_t w;
    if (rst) begin
      spacing_reg  = SPACING_RESET;
      max_dist_reg = MAX_DISTANCE_RESET;
      max_kept_reg = MAX_SAMPLES_RESET;
      started      = 1'b0;
      stopped      = 1'b0;
      dist_capped  = 1'b0;
      for (int k = 0; k < 3; k++) begin
        prev_pt[k] = 0;
        kept_pt[k] = 0;
      end
      path_len   = '0;
      since_kept = '0;
      kept_count = 0;
      expected_beats.delete();
    end else begin
      if (res.valid && res.ready) begin
        if (expected_beats.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result beat kind %0d x %h y %h z %h reason %0d end %0d",
                   $time, res.item_kind, res.out_x, res.out_y, res.out_z, res.end_reason,
                   res.run_end);
        end else begin
          w = expected_beats.pop_front();
          if (res.item_kind !== w.kind || res.out_x !== w.x || res.out_y !== w.y ||
              res.out_z !== w.z || res.end_reason !== w.reason || res.run_end !== w.run_end)
          begin
            err_count++;
            $display("%0t: mismatch expected kind %0d x %h y %h z %h reason %0d end %0d",
                     $time, w.kind, w.x, w.y, w.z, w.reason, w.run_end);
            $display("%0t:          actual   kind %0d x %h y %h z %h reason %0d end %0d",
                     $time, res.item_kind, res.out_x, res.out_y, res.out_z, res.end_reason,
                     res.run_end);
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_SPACING:      spacing_reg  = pwdata;
          REG_MAX_DISTANCE: max_dist_reg = pwdata;
          REG_MAX_SAMPLES:  max_kept_reg = pwdata[10:0];
          default: ;
        endcase
      end
      if (pts.valid && pts.ready)
        advance_path(pts.point_x, pts.point_y, pts.point_z, pts.final_point, pts.path_hit);
    end
  end

endmodule

// File: verif/tb_polyline_arc_length_resampler_unit.sv
module tb_polyline_arc_length_resampler_unit
  import palr_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         STALL_LIMIT = 20000;
  localparam int         SETTLE      = 400;
  localparam logic [3:0] ADDR_UNUSED = 4'd12;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          errors;
  int          pending;
  int          send_idle = 32;
  int          recv_idle = 68;
  int          quiet = 0;

  palr_point_if  points_ch ();
  palr_result_if results_ch ();

  polyline_arc_length_resampler_unit u_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .points  (points_ch),
    .results (results_ch)
  );

  palr_path_checker u_checker (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .pready  (pready),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .pts     (points_ch),
    .res     (results_ch),
    .errors  (errors),
    .pending (pending)
  );

  always #5 clk = ~clk;

  initial begin
    points_ch.valid       = 1'b0;
    points_ch.point_x     = '0;
    points_ch.point_y     = '0;
    points_ch.point_z     = '0;
    points_ch.final_point = 1'b0;
    points_ch.path_hit    = 1'b0;
    results_ch.ready      = 1'b0;
  end

  always @(posedge clk) begin
    results_ch.ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (rst || (points_ch.valid && points_ch.ready) || (results_ch.valid && results_ch.ready) ||
        (psel && penable))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("FAIL polyline_arc_length_resampler_unit");
      $finish;
    end
  end

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            logic fin, logic hit);
    while ($urandom_range(99) < send_idle) begin
      points_ch.valid <= 1'b0;
      @(posedge clk);
    end
    points_ch.valid       <= 1'b1;
    points_ch.point_x     <= x;
    points_ch.point_y     <= y;
    points_ch.point_z     <= z;
    points_ch.final_point <= fin;
    points_ch.path_hit    <= hit;
    @(posedge clk);
    while (!points_ch.ready) @(posedge clk);
  endtask

  task automatic drain_results();
    points_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic apb_write(logic [3:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // The block may still be working on a point that yields nothing, so let it settle.
  task automatic set_registers(logic [31:0] spacing, logic [31:0] max_dist,
                               logic [10:0] max_kept);
    drain_results();
    repeat (SETTLE) @(posedge clk);
    apb_write({REG_SPACING, 2'b00}, spacing);
    apb_write({REG_MAX_DISTANCE, 2'b00}, max_dist);
    apb_write({REG_MAX_SAMPLES, 2'b00}, {21'd0, max_kept});
  endtask

  task automatic random_paths(int count);
    int   sent;
    int   len;
    int   mode;
    int   step;
    int   px;
    int   py;
    int   pz;
    logic fin;
    sent = 0;
    while (sent < count) begin
      len  = $urandom_range(1, 10);
      mode = $urandom_range(9);
      case ($urandom_range(2))
        0:       step = 40;
        1:       step = 400;
        default: step = 4000;
      endcase
      px = int'($urandom_range(40000)) - 20000;
      py = int'($urandom_range(40000)) - 20000;
      pz = int'($urandom_range(40000)) - 20000;
      for (int i = 0; i < len; i++) begin
        if (mode == 0) begin
          px = $urandom;
          py = $urandom;
          pz = $urandom;
        end else if (i == 0 || $urandom_range(7) != 0) begin
          px = px + int'($urandom_range(2 * step)) - step;
          py = py + int'($urandom_range(2 * step)) - step;
          pz = pz + int'($urandom_range(2 * step)) - step;
        end
        fin = (i == len - 1);
        send_point(px, py, pz, fin, 1'($urandom_range(1)));
        sent++;
        if ($urandom_range(59) == 0) drain_results();
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_point(32'd0, 32'd0, 32'd0, 1'b1, 1'b1);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0);
    send_point(32'd100, -32'sd50, 32'd20, 1'b0, 1'b1);
    send_point(32'd100, -32'sd50, 32'd20, 1'b1, 1'b1);
    send_point(32'd0, 32'd0, 32'd0, 1'b0, 1'b0);
    send_point(32'd1000, 32'd0, 32'd0, 1'b0, 1'b0);
    send_point(32'd2000, 32'd0, 32'd0, 1'b1, 1'b0);

    set_registers(32'd16, 32'd40, 11'd0);
    send_point(32'd0, 32'd0, 32'd0, 1'b0, 1'b0);
    send_point(32'd160, -32'sd160, 32'd80, 1'b0, 1'b0);
    send_point(32'd5, 32'd5, 32'd5, 1'b0, 1'b0);
    send_point(32'd9, 32'd9, 32'd9, 1'b1, 1'b1);

    set_registers(32'd16, 32'd0, 11'd2);
    send_point(32'd0, 32'd0, 32'd0, 1'b0, 1'b0);
    send_point(32'd32, 32'd0, 32'd0, 1'b0, 1'b0);
    send_point(32'd64, 32'd0, 32'd0, 1'b0, 1'b0);
    send_point(32'd96, 32'd0, 32'd0, 1'b1, 1'b1);
    drain_results();
    apb_write(ADDR_UNUSED, $urandom);

    for (int phase = 0; phase < 6; phase++) begin
      send_idle = (phase < 2) ? 32 : (phase < 4) ? 68 : 0;
      recv_idle = (phase < 2) ? 68 : (phase < 4) ? 32 : 0;
      case (phase)
        0:       set_registers(32'd16, 32'd0, 11'd0);
        1:       set_registers(32'd300, 32'd5000, 11'd0);
        2:       set_registers(32'hFFFF_FFFF, 32'd0, 11'd1);
        3:       set_registers(32'd100, 32'hFFFF_FFFF, 11'd1024);
        4:       set_registers(32'd16, 32'd2000, 11'd3);
        default: set_registers(32'd40, 32'd800, 11'd2);
      endcase
      random_paths(110);
    end

    drain_results();
    repeat (SETTLE) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("PASS polyline_arc_length_resampler_unit");
    else
      $display("FAIL polyline_arc_length_resampler_unit");
    $finish;
  end

endmodule
